>>> rtl/tgds_pkg.sv
// Shared constants, types and a helper function of the trilinear grid density sampler.
`default_nettype none
package tgds_pkg;

   localparam int GRID_DIM    = 32;
   localparam int FRAC_BITS   = 16;
   localparam int CELL_W      = $clog2(GRID_DIM);
   localparam int SIZE_W      = CELL_W + 1;
   localparam int CSR_W       = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int VOX_W       = 5;
   localparam int POS_W       = 16;
   localparam int VAL_W       = 16;
   localparam int NUM_BANKS   = 8;
   localparam int BANK_AW     = 3 * (CELL_W - 1);
   localparam int BANK_DEPTH  = 1 << BANK_AW;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z = 2'd2;

   localparam logic [CSR_W-1:0] SIZE_RESET = 6'd32;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic [CSR_W-1:0] x;
      logic [CSR_W-1:0] y;
      logic [CSR_W-1:0] z;
   } grid_size_type;

   // One queued item. For a write, x0/y0/z0 hold the voxel index and dens the value.
   typedef struct packed {
      logic                 cmd;
      logic [CELL_W-1:0]    x0;
      logic [CELL_W-1:0]    x1;
      logic [CELL_W-1:0]    y0;
      logic [CELL_W-1:0]    y1;
      logic [CELL_W-1:0]    z0;
      logic [CELL_W-1:0]    z1;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
      logic [FRAC_BITS-1:0] fz;
      logic [VAL_W-1:0]     dens;
   } item_type;

   typedef struct packed {
      logic [CELL_W-1:0]    lo;
      logic [CELL_W-1:0]    hi;
      logic [FRAC_BITS-1:0] frac;
   } axis_type;

   // A size of zero acts as one; sizes above the grid saturate to the grid.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CSR_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = SIZE_W'(1);
      end else if (32'(s) > GRID_DIM) begin
         r = SIZE_W'(GRID_DIM);
      end else begin
         r = SIZE_W'(s);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tgds_front.sv
// Front end: accepts items, splits sample positions into cells and fractions.
`default_nettype none
module tgds_front import tgds_pkg::*; (
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_command,
   input  wire logic [POS_W-1:0]     req_pos_x,
   input  wire logic [POS_W-1:0]     req_pos_y,
   input  wire logic [POS_W-1:0]     req_pos_z,
   input  wire logic [VOX_W-1:0]     req_voxel_x,
   input  wire logic [VOX_W-1:0]     req_voxel_y,
   input  wire logic [VOX_W-1:0]     req_voxel_z,
   input  wire logic [VAL_W-1:0]     req_voxel_density,
   input  wire grid_size_type        grid_size,
   input  wire logic                 queue_full,
   output logic                      push,
   output item_type                  push_item
);

   function automatic axis_type split_axis(input logic [POS_W-1:0] pos,
                                           input logic [CSR_W-1:0] size_reg);
      logic [SIZE_W-1:0]           s;
      logic [SIZE_W-1:0]           smax;
      logic [POS_W+SIZE_W-1:0]     scaled;
      logic [SIZE_W-1:0]           c;
      logic [SIZE_W-1:0]           lo;
      logic [FRAC_BITS+15:0]       fext;
      axis_type                    r;
      s      = eff_size(size_reg);
      smax   = s - SIZE_W'(1);
      scaled = (POS_W+SIZE_W)'(pos) * (POS_W+SIZE_W)'(s);
      c      = scaled[POS_W +: SIZE_W];
      lo     = (c > smax) ? smax : c;
      r.lo   = lo[CELL_W-1:0];
      r.hi   = (lo == smax) ? smax[CELL_W-1:0] : lo[CELL_W-1:0] + CELL_W'(1);
      // The 16-bit fraction is placed at the top and cut to FRAC_BITS bits.
      fext   = {scaled[15:0], FRAC_BITS'(0)};
      r.frac = fext[FRAC_BITS+15 -: FRAC_BITS];
      return r;
   endfunction

   axis_type ax_x, ax_y, ax_z;
   logic     accept;
   logic     in_range;

   assign busy   = queue_full;
   assign accept = start && !queue_full;

   always_comb begin
      ax_x     = split_axis(req_pos_x, grid_size.x);
      ax_y     = split_axis(req_pos_y, grid_size.y);
      ax_z     = split_axis(req_pos_z, grid_size.z);
      in_range = (32'(req_voxel_x) < GRID_DIM) && (32'(req_voxel_y) < GRID_DIM) &&
                 (32'(req_voxel_z) < GRID_DIM);
      push_item.cmd  = req_command;
      push_item.dens = req_voxel_density;
      push_item.x1   = ax_x.hi;
      push_item.y1   = ax_y.hi;
      push_item.z1   = ax_z.hi;
      push_item.fx   = ax_x.frac;
      push_item.fy   = ax_y.frac;
      push_item.fz   = ax_z.frac;
      unique case (req_command)
         CMD_SAMPLE: begin
            push_item.x0 = ax_x.lo;
            push_item.y0 = ax_y.lo;
            push_item.z0 = ax_z.lo;
            push         = accept;
         end
         default: begin
            push_item.x0 = CELL_W'(req_voxel_x);
            push_item.y0 = CELL_W'(req_voxel_y);
            push_item.z0 = CELL_W'(req_voxel_z);
            // A write outside the grid is dropped here and never queued.
            push         = accept && in_range;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/tgds_queue.sv
// Short item queue between the front end and the back end.
`default_nettype none
module tgds_queue import tgds_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output logic          empty,
   output logic          full
);

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tgds_back.sv
// Back end: eight parity-banked voxel memories and the pipelined trilinear blend.
`default_nettype none
module tgds_back import tgds_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type head_item,
   input  wire logic     queue_empty,
   output logic          pop,
   output logic          rsp_valid,
   output logic [VAL_W-1:0] rsp_density
);

   localparam int AW  = VAL_W + FRAC_BITS;       // x-blend result width
   localparam int BW  = AW + FRAC_BITS + 1;      // y and z blend sum width
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [BW-1:0] HALF_Y = BW'(1) << (FRAC_BITS - 1);
   localparam logic [BW-1:0] HALF_Z = BW'(1) << (2 * FRAC_BITS - 1);

   logic                 sample_go, write_go;
   logic [2:0]           wbank;
   logic [BANK_AW-1:0]   waddr;
   logic [BANK_AW-1:0]   bank_addr [NUM_BANKS];
   logic                 bank_we   [NUM_BANKS];
   logic [VAL_W-1:0]     rdata_ff  [NUM_BANKS];

   // Stage 1 control: parity bits of the lower and upper corner per axis.
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_xp_ff, s1_xp_in;
   logic [1:0]           s1_yp_ff, s1_yp_in;
   logic [1:0]           s1_zp_ff, s1_zp_in;
   logic [FRAC_BITS-1:0] s1_fx_ff, s1_fx_in;
   logic [FRAC_BITS-1:0] s1_fy_ff, s1_fy_in;
   logic [FRAC_BITS-1:0] s1_fz_ff, s1_fz_in;

   logic                 s2_valid_ff, s2_valid_in;
   logic [AW-1:0]        s2_a_ff [4];
   logic [AW-1:0]        s2_a_in [4];
   logic [FRAC_BITS-1:0] s2_fy_ff, s2_fy_in;
   logic [FRAC_BITS-1:0] s2_fz_ff, s2_fz_in;

   logic                 s3_valid_ff, s3_valid_in;
   logic [AW-1:0]        s3_b_ff [2];
   logic [AW-1:0]        s3_b_in [2];
   logic [FRAC_BITS-1:0] s3_fz_ff, s3_fz_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_density_ff, rsp_density_in;

   assign pop       = !queue_empty;
   assign sample_go = pop && (head_item.cmd == CMD_SAMPLE);
   assign write_go  = pop && (head_item.cmd == CMD_WRITE);
   assign wbank     = {head_item.z0[0], head_item.y0[0], head_item.x0[0]};
   assign waddr     = {head_item.z0[CELL_W-1:1], head_item.y0[CELL_W-1:1],
                       head_item.x0[CELL_W-1:1]};

   // Adjacent corners differ in parity, so each bank serves one corner. A clamped
   // axis has both corners equal and both read the bank of the lower one.
   always_comb begin
      logic [CELL_W-1:0] xs, ys, zs;
      for (int b = 0; b < NUM_BANKS; b++) begin
         xs = (head_item.x0[0] == b[0]) ? head_item.x0 : head_item.x1;
         ys = (head_item.y0[0] == b[1]) ? head_item.y0 : head_item.y1;
         zs = (head_item.z0[0] == b[2]) ? head_item.z0 : head_item.z1;
         if (write_go) begin
            bank_addr[b] = waddr;
            bank_we[b]   = (wbank == 3'(b));
         end else begin
            bank_addr[b] = {zs[CELL_W-1:1], ys[CELL_W-1:1], xs[CELL_W-1:1]};
            bank_we[b]   = 1'b0;
         end
      end
   end

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic [VAL_W-1:0] mem [BANK_DEPTH];
      always_ff @(posedge clock) begin
         if (bank_we[g]) begin
            mem[bank_addr[g]] <= head_item.dens;
         end
         rdata_ff[g] <= mem[bank_addr[g]];
      end
   end

   always_comb begin
      s1_valid_in = sample_go;
      s1_xp_in    = {head_item.x1[0], head_item.x0[0]};
      s1_yp_in    = {head_item.y1[0], head_item.y0[0]};
      s1_zp_in    = {head_item.z1[0], head_item.z0[0]};
      s1_fx_in    = head_item.fx;
      s1_fy_in    = head_item.fy;
      s1_fz_in    = head_item.fz;
   end

   // Stage 1: blend along x for the four (y, z) corner pairs.
   always_comb begin
      logic [FRAC_BITS:0] gx;
      logic [VAL_W-1:0]   c0, c1;
      logic [AW:0]        sum;
      gx = ONE - (FRAC_BITS+1)'(s1_fx_ff);
      for (int k = 0; k < 2; k++) begin
         for (int j = 0; j < 2; j++) begin
            c0  = rdata_ff[{s1_zp_ff[k], s1_yp_ff[j], s1_xp_ff[0]}];
            c1  = rdata_ff[{s1_zp_ff[k], s1_yp_ff[j], s1_xp_ff[1]}];
            sum = (AW+1)'(c0) * (AW+1)'(gx) + (AW+1)'(c1) * (AW+1)'(s1_fx_ff);
            s2_a_in[2*k+j] = sum[AW-1:0];
         end
      end
      s2_valid_in = s1_valid_ff;
      s2_fy_in    = s1_fy_ff;
      s2_fz_in    = s1_fz_ff;
   end

   // Stage 2: blend along y, rounded half up by FRAC_BITS.
   always_comb begin
      logic [FRAC_BITS:0] gy;
      logic [BW-1:0]      sum;
      gy = ONE - (FRAC_BITS+1)'(s2_fy_ff);
      for (int k = 0; k < 2; k++) begin
         sum = BW'(s2_a_ff[2*k]) * BW'(gy) + BW'(s2_a_ff[2*k+1]) * BW'(s2_fy_ff) + HALF_Y;
         s3_b_in[k] = sum[FRAC_BITS +: AW];
      end
      s3_valid_in = s2_valid_ff;
      s3_fz_in    = s2_fz_ff;
   end

   // Stage 3: blend along z, rounded half up by twice FRAC_BITS, then saturated.
   always_comb begin
      logic [FRAC_BITS:0]       gz;
      logic [BW-1:0]            sum;
      logic [BW-2*FRAC_BITS-1:0] v;
      gz  = ONE - (FRAC_BITS+1)'(s3_fz_ff);
      sum = BW'(s3_b_ff[0]) * BW'(gz) + BW'(s3_b_ff[1]) * BW'(s3_fz_ff) + HALF_Z;
      v   = sum[BW-1:2*FRAC_BITS];
      if (v > (BW-2*FRAC_BITS)'({VAL_W{1'b1}})) begin
         rsp_density_in = {VAL_W{1'b1}};
      end else begin
         rsp_density_in = v[VAL_W-1:0];
      end
      rsp_valid_in = s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_xp_ff       <= s1_xp_in;
      s1_yp_ff       <= s1_yp_in;
      s1_zp_ff       <= s1_zp_in;
      s1_fx_ff       <= s1_fx_in;
      s1_fy_ff       <= s1_fy_in;
      s1_fz_ff       <= s1_fz_in;
      s2_a_ff        <= s2_a_in;
      s2_fy_ff       <= s2_fy_in;
      s2_fz_ff       <= s2_fz_in;
      s3_b_ff        <= s3_b_in;
      s3_fz_ff       <= s3_fz_in;
      rsp_density_ff <= rsp_density_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_density = rsp_density_ff;

endmodule
`default_nettype wire

>>> rtl/trilinear_grid_density_sampler_top.sv
// Top level of the trilinear grid density sampler: grid size registers and block wiring.
// One item is accepted per cycle; busy rises only when the four-entry queue is full,
// and the back end drains one item every cycle, so a steady stream is taken back to back.
// A sample's result leaves the blend stage registers on rsp_density with rsp_valid high;
// a write gives no result. The rate is set by the eight parity banks, each read once a cycle.
// Synchronous reset sets all grid sizes to 32 and empties the queue and pipeline;
// the voxel memories are not cleared and hold nothing defined until written.
`default_nettype none
module trilinear_grid_density_sampler_top import tgds_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_command,
   input  wire logic [POS_W-1:0]     req_pos_x,
   input  wire logic [POS_W-1:0]     req_pos_y,
   input  wire logic [POS_W-1:0]     req_pos_z,
   input  wire logic [VOX_W-1:0]     req_voxel_x,
   input  wire logic [VOX_W-1:0]     req_voxel_y,
   input  wire logic [VOX_W-1:0]     req_voxel_z,
   input  wire logic [VAL_W-1:0]     req_voxel_density,
   output logic                      rsp_valid,
   output logic [VAL_W-1:0]          rsp_density,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   grid_size_type grid_size_ff, grid_size_in;
   item_type      push_item, head_item;
   logic          push, pop, queue_empty, queue_full;

   always_comb begin
      grid_size_in = grid_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_X: grid_size_in.x = csr_wdata;
            CSR_GRID_Y: grid_size_in.y = csr_wdata;
            CSR_GRID_Z: grid_size_in.z = csr_wdata;
            default:    grid_size_in = grid_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= '{x: SIZE_RESET, y: SIZE_RESET, z: SIZE_RESET};
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   tgds_front u_front (
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_voxel_x       (req_voxel_x),
      .req_voxel_y       (req_voxel_y),
      .req_voxel_z       (req_voxel_z),
      .req_voxel_density (req_voxel_density),
      .grid_size         (grid_size_ff),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   tgds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   tgds_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_item   (head_item),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_density (rsp_density)
   );

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the trilinear grid density sampler top level.
module tb;
   import tgds_pkg::*;

   localparam int VOXELS        = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_command;
   logic [POS_W-1:0]     req_pos_x;
   logic [POS_W-1:0]     req_pos_y;
   logic [POS_W-1:0]     req_pos_z;
   logic [VOX_W-1:0]     req_voxel_x;
   logic [VOX_W-1:0]     req_voxel_y;
   logic [VOX_W-1:0]     req_voxel_z;
   logic [VAL_W-1:0]     req_voxel_density;
   logic                 rsp_valid;
   logic [VAL_W-1:0]     rsp_density;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // Shadow copy of the grid and of the size registers.
   logic [VAL_W-1:0] voxel_model [VOXELS];
   bit               voxel_written [VOXELS];
   logic [CSR_W-1:0] grid_cfg [3];

   logic [VAL_W-1:0] density_due [$];
   int unsigned      mismatch_count;
   int unsigned      stall_cycles;
   int unsigned      items_sent;
   int unsigned      burst_left;
   bit               gaps_on;

   trilinear_grid_density_sampler_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned axis_extent(input logic [CSR_W-1:0] cfg);
      if (cfg == '0) begin
         return 1;
      end else if (cfg > GRID_DIM) begin
         return GRID_DIM;
      end
      return cfg;
   endfunction

   function automatic int unsigned voxel_addr(input int unsigned x, y, z);
      return (z * GRID_DIM + y) * GRID_DIM + x;
   endfunction

   // Lower and upper cell along one axis plus the blend weight toward the upper one.
   function automatic void split_axis(input logic [POS_W-1:0] pos, input logic [CSR_W-1:0] cfg,
                                      output int unsigned lo, output int unsigned hi,
                                      output longint unsigned frac);
      int unsigned     extent;
      longint unsigned scaled;
      longint unsigned f16;
      extent = axis_extent(cfg);
      scaled = 64'(pos) * 64'(extent);
      lo = int'(scaled >> 16);
      if (lo > extent - 1) begin
         lo = extent - 1;
      end
      hi = (lo + 1 > extent - 1) ? extent - 1 : lo + 1;
      f16 = scaled & 64'hFFFF;
      if (FRAC_BITS >= 16) begin
         frac = f16 << (FRAC_BITS - 16);
      end else begin
         frac = f16 >> (16 - FRAC_BITS);
      end
   endfunction

   function automatic longint unsigned voxel_at(input int unsigned x, y, z);
      return 64'(voxel_model[voxel_addr(x, y, z)]);
   endfunction

   function automatic logic [VAL_W-1:0] blend_density(input logic [POS_W-1:0] px, py, pz);
      int unsigned     x0, x1, y0, y1, z0, z1;
      longint unsigned fx, fy, fz, gx, gy, unity;
      longint unsigned a00, a10, a01, a11, b0, b1, v;
      unity = 64'd1 << FRAC_BITS;
      split_axis(px, grid_cfg[0], x0, x1, fx);
      split_axis(py, grid_cfg[1], y0, y1, fy);
      split_axis(pz, grid_cfg[2], z0, z1, fz);
      gx = unity - fx;
      gy = unity - fy;
      a00 = voxel_at(x0, y0, z0) * gx + voxel_at(x1, y0, z0) * fx;
      a10 = voxel_at(x0, y1, z0) * gx + voxel_at(x1, y1, z0) * fx;
      a01 = voxel_at(x0, y0, z1) * gx + voxel_at(x1, y0, z1) * fx;
      a11 = voxel_at(x0, y1, z1) * gx + voxel_at(x1, y1, z1) * fx;
      // The y stage is rounded back to one fraction width, the z stage to none.
      b0 = (a00 * gy + a10 * fy + (unity >> 1)) >> FRAC_BITS;
      b1 = (a01 * gy + a11 * fy + (unity >> 1)) >> FRAC_BITS;
      v = (b0 * (unity - fz) + b1 * fz + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (v > 64'hFFFF) begin
         v = 64'hFFFF;
      end
      return v[VAL_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return POS_W'($urandom);
      endcase
   endfunction

   // At least half of the random writes land inside the cells that samples can reach.
   function automatic logic [VOX_W-1:0] rand_index(input int axis);
      if ($urandom_range(0, 1) == 0) begin
         return VOX_W'($urandom_range(0, axis_extent(grid_cfg[axis]) - 1));
      end
      return VOX_W'($urandom);
   endfunction

   task automatic send_item(input logic cmd, input logic [POS_W-1:0] px, py, pz,
                            input logic [VOX_W-1:0] vx, vy, vz,
                            input logic [VAL_W-1:0] dens);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_command       = cmd;
      req_pos_x         = px;
      req_pos_y         = py;
      req_pos_z         = pz;
      req_voxel_x       = vx;
      req_voxel_y       = vy;
      req_voxel_z       = vz;
      req_voxel_density = dens;
      start             = 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (cmd == CMD_WRITE) begin
         voxel_model[voxel_addr(vx, vy, vz)]   = dens;
         voxel_written[voxel_addr(vx, vy, vz)] = 1'b1;
      end else begin
         density_due.push_back(blend_density(px, py, pz));
      end
   endtask

   task automatic write_voxel(input int unsigned x, y, z, input logic [VAL_W-1:0] dens);
      send_item(CMD_WRITE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                VOX_W'(x), VOX_W'(y), VOX_W'(z), dens);
   endtask

   task automatic sample_density(input logic [POS_W-1:0] px, py, pz);
      int unsigned     xs[2];
      int unsigned     ys[2];
      int unsigned     zs[2];
      longint unsigned frac;
      split_axis(px, grid_cfg[0], xs[0], xs[1], frac);
      split_axis(py, grid_cfg[1], ys[0], ys[1], frac);
      split_axis(pz, grid_cfg[2], zs[0], zs[1], frac);
      // A sample may only read voxels that hold a written value.
      for (int c = 0; c < 8; c++) begin
         if (!voxel_written[voxel_addr(xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1])]) begin
            write_voxel(xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1], VAL_W'($urandom));
         end
      end
      send_item(CMD_SAMPLE, px, py, pz, VOX_W'($urandom), VOX_W'($urandom),
                VOX_W'($urandom), VAL_W'($urandom));
   endtask

   // Stop sending and wait until the block has drained.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (density_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx <= CSR_GRID_Z) begin
         grid_cfg[idx] = val;
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_grid(input logic [CSR_W-1:0] sx, sy, sz);
      settle();
      write_csr(CSR_GRID_X, sx);
      write_csr(CSR_GRID_Y, sy);
      write_csr(CSR_GRID_Z, sz);
   endtask

   // Density extremes at the low and high corners of the full grid, with exact halves.
   task automatic test_corner_extremes();
      write_voxel(GRID_DIM - 1, GRID_DIM - 1, GRID_DIM - 1, '1);
      sample_density('1, '1, '1);
      write_voxel(0, 0, 0, '0);
      write_voxel(1, 0, 0, '1);
      sample_density('0, '0, '0);
      sample_density(16'h0400, '0, '0);
      sample_density(16'h0400, 16'h0400, 16'h0400);
   endtask

   // Size of one and of zero, saturation above the grid, and the unused register index.
   task automatic test_grid_registers();
      set_grid(6'd1, 6'd1, 6'd1);
      sample_density(rand_pos(), rand_pos(), rand_pos());
      set_grid(6'd0, 6'd0, 6'd0);
      sample_density('1, 16'h8000, '0);
      set_grid(6'd63, 6'd33, 6'd40);
      sample_density('1, '1, '1);
      settle();
      write_csr(CSR_UNUSED, 6'd5);
      sample_density(16'hFFF0, 16'h0001, 16'h7FFF);
   endtask

   task automatic test_random_streams();
      int unsigned goal;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_grid(SIZE_RESET, SIZE_RESET, SIZE_RESET);
            1: set_grid(6'd1, 6'd32, 6'd2);
            2: set_grid(6'd0, 6'd63, 6'd17);
            default: set_grid(CSR_W'($urandom_range(0, 63)), CSR_W'($urandom_range(0, 63)),
                              CSR_W'($urandom_range(0, 63)));
         endcase
         gaps_on = (phase % 3) != 1;
         goal = items_sent + 200;
         while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 7) begin
               sample_density(rand_pos(), rand_pos(), rand_pos());
            end else begin
               write_voxel(rand_index(0), rand_index(1), rand_index(2), VAL_W'($urandom));
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // Result checking and the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (density_due.size() == 0) begin
               $error("density: expected none, actual %0h", rsp_density);
               mismatch_count++;
            end else if (rsp_density !== density_due[0]) begin
               $error("density: expected %0h, actual %0h", density_due[0], rsp_density);
               mismatch_count++;
               void'(density_due.pop_front());
            end else begin
               void'(density_due.pop_front());
            end
         end
         if (rsp_valid || (start && !busy)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_command       = CMD_WRITE;
      req_pos_x         = '0;
      req_pos_y         = '0;
      req_pos_z         = '0;
      req_voxel_x       = '0;
      req_voxel_y       = '0;
      req_voxel_z       = '0;
      req_voxel_density = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_GRID_X;
      csr_wdata         = '0;
      mismatch_count    = 0;
      items_sent        = 0;
      burst_left        = 0;
      gaps_on           = 1'b1;
      for (int i = 0; i < 3; i++) begin
         grid_cfg[i] = SIZE_RESET;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_extremes();
      test_grid_registers();
      test_random_streams();

      settle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/tgds_pkg.sv
rtl/tgds_front.sv
rtl/tgds_queue.sv
rtl/tgds_back.sv
rtl/trilinear_grid_density_sampler_top.sv
test/tb.sv
